>>> sv/ptrs_pkg.sv
// Shared types and constants of the periodic task release scheduler:
// request codes, slot status codes, bus widths and controller/datapath links.
// No dependencies.
package ptrs_pkg;

  localparam int unsigned IN_W         = 8;   // request tdata: action, slot, pad
  localparam int unsigned OUT_W        = 72;  // result tdata, 70 used bits
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned NUM_CFG      = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned MASK_W       = 8;
  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned SLOT_FIELD_W = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned RANGE_W      = 5;   // holds slot counts up to 31

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_COMPLETE = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  localparam logic [STATUS_W-1:0] ST_READY   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXEC    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted request, clear the result staging
    logic time_inc;  // advance the tick counter
    logic slot_step; // process the walk slot and advance the walk index
    logic dispatch;  // pick the highest-priority ready slot
    logic access;    // complete or read the addressed slot
    logic load_out;  // move the staged result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    walk_last;
    logic    out_free;
  } sts_t;

  // Period of a slot after reset; slots past the register list keep 40.
  function automatic logic [PERIOD_W-1:0] default_period(input int unsigned idx);
    logic [PERIOD_W-1:0] p;
    case (idx)
      0:       p = 16'd10;
      1:       p = 16'd17;
      2:       p = 16'd20;
      3:       p = 16'd22;
      4:       p = 16'd25;
      5:       p = 16'd25;
      6:       p = 16'd27;
      default: p = 16'd40;
    endcase
    return p;
  endfunction

endpackage

>>> sv/ptrs_ctrl.sv
// Controller of the periodic task release scheduler: request sequencing.
// Depends on ptrs_pkg (command and status structs, request codes).
module ptrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  ptrs_pkg::sts_t sts_i,
  output ptrs_pkg::cmd_t cmd_o
);
  import ptrs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i && ready_q) begin
          cmd_o.capture = 1'b1;
          ready_d       = 1'b0;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.action) inside
          ACT_TICK: begin
            cmd_o.time_inc = 1'b1;
            state_d        = S_WALK;
          end
          ACT_DISPATCH: begin
            cmd_o.dispatch = 1'b1;
            state_d        = S_FINISH;
          end
          ACT_COMPLETE, ACT_READ: begin
            cmd_o.access = 1'b1;
            state_d      = S_FINISH;
          end
        endcase
      end
      S_WALK: begin
        cmd_o.slot_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          ready_d        = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign s_tready_o = ready_q;

endmodule

>>> sv/ptrs_dp.sv
// Datapath of the periodic task release scheduler: slot state, periods,
// tick counter, result staging and output register. Depends on ptrs_pkg.
module ptrs_dp #(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptrs_pkg::cmd_t                   cmd_i,
  output ptrs_pkg::sts_t                   sts_o,
  input  logic                             cfg_we_i,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptrs_pkg::PERIOD_W-1:0]    cfg_data_i,
  input  logic [ptrs_pkg::IN_W-1:0]        in_data_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [ptrs_pkg::OUT_W-1:0]       m_tdata_o
);
  import ptrs_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  action_e                  action_q;
  logic [SLOT_FIELD_W-1:0]  slot_q;
  logic [SLOT_W-1:0]        idx_q;
  logic [TIME_W-1:0]        tick_time_q;
  logic [PERIOD_W-1:0]      period_q   [NUM_SLOTS];
  logic [TIME_W-1:0]        next_rel_q [NUM_SLOTS];
  logic [STATUS_W-1:0]      status_q   [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0]   missed_q   [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0]   queued_q   [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0]   maxq_q     [NUM_SLOTS];
  logic [MASK_W-1:0]        rel_mask_q;
  logic [MASK_W-1:0]        mis_mask_q;
  logic                     disp_valid_q;
  logic [SLOT_FIELD_W-1:0]  disp_slot_q;
  logic [SLOT_W-1:0]        sel_q;
  logic                     show_q;
  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_data_q;

  // walk slot terms
  logic                   due;
  logic                   late;
  logic [TIME_W-1:0]      rel_sum;
  logic [COUNT_WIDTH-1:0] miss_inc;
  logic [COUNT_WIDTH-1:0] queue_inc;
  // dispatch pick
  logic                   found;
  logic [SLOT_W-1:0]      pick;
  // addressed slot and config index checks
  logic                   slot_ok;
  logic [SLOT_W-1:0]      slot_idx;
  logic                   cfg_ok;
  // staged result fields
  logic [FIELD_W-1:0]     res_missed;
  logic [FIELD_W-1:0]     res_queued;
  logic [FIELD_W-1:0]     res_maxq;
  logic [STATUS_W-1:0]    res_status;

  assign due       = tick_time_q >= next_rel_q[idx_q];
  assign rel_sum   = next_rel_q[idx_q] + TIME_W'(period_q[idx_q]);
  assign late      = (status_q[idx_q] == ST_READY) || (status_q[idx_q] == ST_EXEC);
  assign miss_inc  = sat_inc(missed_q[idx_q]);
  assign queue_inc = sat_inc(queued_q[idx_q]);

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (status_q[i] == ST_READY) begin
        found = 1'b1;
        pick  = SLOT_W'(i);
      end
    end
  end

  assign slot_ok  = RANGE_W'(slot_q) < RANGE_W'(NUM_SLOTS);
  assign slot_idx = SLOT_W'(slot_q);
  assign cfg_ok   = RANGE_W'(cfg_idx_i) < RANGE_W'(NUM_SLOTS);

  assign res_missed = show_q ? FIELD_W'(missed_q[sel_q]) : '0;
  assign res_queued = show_q ? FIELD_W'(queued_q[sel_q]) : '0;
  assign res_maxq   = show_q ? FIELD_W'(maxq_q[sel_q])   : '0;
  assign res_status = show_q ? status_q[sel_q]           : '0;

  assign sts_o.action    = action_q;
  assign sts_o.walk_last = idx_q == SLOT_W'(NUM_SLOTS - 1);
  assign sts_o.out_free  = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q     <= ACT_TICK;
      slot_q       <= '0;
      idx_q        <= '0;
      tick_time_q  <= '0;
      rel_mask_q   <= '0;
      mis_mask_q   <= '0;
      disp_valid_q <= 1'b0;
      disp_slot_q  <= '0;
      sel_q        <= '0;
      show_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
        period_q[i]   <= default_period(i);
        next_rel_q[i] <= '0;
        status_q[i]   <= ST_BLOCKED;
        missed_q[i]   <= '0;
        queued_q[i]   <= '0;
        maxq_q[i]     <= '0;
      end
    end else begin
      if (cfg_we_i && cfg_ok) begin
        period_q[SLOT_W'(cfg_idx_i)] <= cfg_data_i;
      end

      if (cmd_i.capture) begin
        action_q     <= action_e'(in_data_i[1:0]);
        slot_q       <= in_data_i[4:2];
        idx_q        <= '0;
        rel_mask_q   <= '0;
        mis_mask_q   <= '0;
        disp_valid_q <= 1'b0;
        disp_slot_q  <= '0;
        show_q       <= 1'b0;
      end

      if (cmd_i.time_inc) begin
        tick_time_q <= tick_time_q + 1'b1;
      end

      if (cmd_i.slot_step) begin
        idx_q <= idx_q + 1'b1;
        if (due) begin
          next_rel_q[idx_q] <= rel_sum;
          for (int unsigned b = 0; b < MASK_W; b++) begin
            if (b < NUM_SLOTS && idx_q == SLOT_W'(b)) begin
              rel_mask_q[b] <= 1'b1;
              if (late) begin
                mis_mask_q[b] <= 1'b1;
              end
            end
          end
          if (late) begin
            missed_q[idx_q] <= miss_inc;
            queued_q[idx_q] <= queue_inc;
            if (queue_inc > maxq_q[idx_q]) begin
              maxq_q[idx_q] <= queue_inc;
            end
          end else begin
            status_q[idx_q] <= ST_READY;
          end
        end
      end

      if (cmd_i.dispatch && found) begin
        status_q[pick] <= ST_EXEC;
        if (queued_q[pick] != '0) begin
          queued_q[pick] <= queued_q[pick] - 1'b1;
        end
        disp_valid_q <= 1'b1;
        disp_slot_q  <= SLOT_FIELD_W'(pick);
        sel_q        <= pick;
        show_q       <= 1'b1;
      end

      if (cmd_i.access && slot_ok) begin
        if (action_q == ACT_COMPLETE) begin
          status_q[slot_idx] <= ST_BLOCKED;
        end
        sel_q  <= slot_idx;
        show_q <= 1'b1;
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {2'b00, res_status, res_maxq, res_queued, res_missed,
                     mis_mask_q, rel_mask_q, disp_slot_q, disp_valid_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // a slot can miss a deadline only on a tick that releases it
  a_miss_in_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mis_mask_q & ~rel_mask_q) == '0)
    else $error("missed mask bit without release");

  // a dispatched slot shows as executing when its result is loaded
  a_dispatch_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && disp_valid_q |-> status_q[sel_q] == ST_EXEC)
    else $error("dispatched slot not executing");

  // queue maximum never falls below the current queue depth
  a_max_covers_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> maxq_q[sel_q] >= queued_q[sel_q])
    else $error("queue maximum below queue depth");

endmodule

>>> sv/periodic_task_release_scheduler.sv
// Top level of the periodic task release scheduler.
// Depends on ptrs_pkg, ptrs_ctrl and ptrs_dp.
//
// Usage:
//   Requests enter on the s_axis group; tdata[1:0] is the action (tick,
//   dispatch, complete, read) and tdata[4:2] the slot for complete and read.
//   Each request gives exactly one result on the m_axis group, in order.
//   Slot periods are written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no request is in flight; register i sets the period of slot i.
// Timing:
//   One request is handled at a time. A tick walks all NUM_SLOTS slots, one
//   per cycle through the shared compare/add unit, after the decode state
//   advances the tick counter. Dispatch, complete and read are handled in
//   the decode state. Every request then waits in the finish state until
//   the result register is free. s_axis_tready_o rises again on the cycle
//   the result is loaded, so a new request is taken only once the last
//   result has been loaded.
// Reset and stalls:
//   Reset loads the default periods, clears time and counters and blocks
//   every slot. The result register holds while m_axis_tready_i is low; the
//   next request is still accepted and worked on, and waits at its end for
//   the result register to drain.
module periodic_task_release_scheduler #(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: action[1:0], slot[4:2], zero pad[7:5]
  input  logic [ptrs_pkg::IN_W-1:0]      s_axis_tdata_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: dispatch_valid[0], dispatch_slot[3:1], released_mask[11:4],
  // missed_mask[19:12], slot_missed[35:20], slot_queued[51:36],
  // slot_max_queued[67:52], slot_status[69:68], zero pad[71:70]
  output logic [ptrs_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // period register writes
  input  logic                           cfg_we_i,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptrs_pkg::PERIOD_W-1:0]  cfg_data_i
);
  import ptrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptrs_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> bench/tb_periodic_task_release_scheduler.sv
// Self-checking bench for the periodic task release scheduler: drives tick, dispatch,
// complete and read requests with random idling, checks results against plan or predictor.
// Depends on ptrs_pkg and periodic_task_release_scheduler.
module tb_periodic_task_release_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrs_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // A tick walks every slot; leave a wide margin after the last result.
  localparam int unsigned TAIL_CYCLES = 32;

  // One result, laid out exactly as on m_axis_tdata_o (first member is the top bit).
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] max_queued;
    logic [15:0] queued;
    logic [15:0] missed;
    logic [7:0]  missed_mask;
    logic [7:0]  released_mask;
    logic [2:0]  dispatch_slot;
    logic        dispatch_valid;
  } sched_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // Directed plan row. For ROW_CFG the slot column is the register index.
  typedef struct packed {
    row_kind_e     kind;
    action_e       action;
    logic [2:0]    slot;
    logic [15:0]   value;
    logic          typed;
    sched_result_t expd;
  } plan_row_t;

  typedef enum int {PER_ONES, PER_TINY, PER_SHORT, PER_MIXED, PER_MAX} period_mix_e;

  localparam logic [15:0] DEFAULT_PERIOD [SLOTS] = '{10, 17, 20, 22, 25, 25, 27, 40};

  // Random phases. Large periods freeze slots for the rest of the run, so they go last.
  localparam period_mix_e PHASE_MIX [8] =
    '{PER_ONES, PER_TINY, PER_SHORT, PER_TINY, PER_SHORT, PER_MIXED, PER_MIXED, PER_MAX};
  localparam int          PHASE_LEN [8] = '{250, 250, 250, 240, 250, 250, 240, 120};
  localparam bit          PHASE_CALM[8] = '{0, 0, 0, 1, 0, 0, 0, 0};

  // Results that can be read off at a glance.
  localparam sched_result_t BLOCKED_VIEW =
    '{ST_BLOCKED, 16'd0, 16'd0, 16'd0, 8'h00, 8'h00, 3'd0, 1'b0};
  localparam sched_result_t NOTHING_READY = '0;
  localparam sched_result_t FIRST_RELEASE =
    '{2'd0, 16'd0, 16'd0, 16'd0, 8'h00, 8'hFF, 3'd0, 1'b0};
  localparam sched_result_t SLOT0_DISPATCHED =
    '{ST_EXEC, 16'd0, 16'd0, 16'd0, 8'h00, 8'h00, 3'd0, 1'b1};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [IN_W-1:0]      s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PERIOD_W-1:0]  cfg_data_i;

  // Predictor state, kept in step with every accepted request and register write.
  logic [31:0] pred_time;
  logic [31:0] pred_next_rel [SLOTS];
  logic [1:0]  pred_status   [SLOTS];
  logic [15:0] pred_missed   [SLOTS];
  logic [15:0] pred_queued   [SLOTS];
  logic [15:0] pred_max_q    [SLOTS];
  logic [15:0] pred_period   [SLOTS];

  sched_result_t pending_results[$];
  plan_row_t     directed_plan[$];
  sched_result_t want_res;
  sched_result_t got_res;
  logic [2:0]    last_dispatched = 3'd0;
  bit            no_idle = 1'b0;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;

  periodic_task_release_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) cycle_count++;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Saturating 16-bit counter step.
  function automatic logic [15:0] bump_count(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Predict the result of one request and advance the predictor state.
  function automatic sched_result_t predict_schedule(action_e act, logic [2:0] slot);
    sched_result_t r;
    logic          found;
    r = '0;
    found = 1'b0;
    case (act)
      ACT_TICK: begin
        pred_time = pred_time + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (pred_time >= pred_next_rel[i]) begin
            pred_next_rel[i] = pred_next_rel[i] + {16'd0, pred_period[i]};
            r.released_mask[i] = 1'b1;
            // A job still pending when the next one arrives is a missed deadline.
            if (pred_status[i] == ST_READY || pred_status[i] == ST_EXEC) begin
              pred_missed[i] = bump_count(pred_missed[i]);
              pred_queued[i] = bump_count(pred_queued[i]);
              if (pred_queued[i] > pred_max_q[i]) pred_max_q[i] = pred_queued[i];
              r.missed_mask[i] = 1'b1;
            end else begin
              pred_status[i] = ST_READY;
            end
          end
        end
      end
      ACT_DISPATCH: begin
        // Lowest index wins: slot 0 has the highest priority.
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && pred_status[i] == ST_READY) begin
            found = 1'b1;
            pred_status[i] = ST_EXEC;
            if (pred_queued[i] != 16'd0) pred_queued[i] = pred_queued[i] - 16'd1;
            r.dispatch_valid = 1'b1;
            r.dispatch_slot  = 3'(i);
            r.missed         = pred_missed[i];
            r.queued         = pred_queued[i];
            r.max_queued     = pred_max_q[i];
            r.status         = pred_status[i];
          end
        end
      end
      default: begin
        if (act == ACT_COMPLETE) pred_status[slot] = ST_BLOCKED;
        r.missed     = pred_missed[slot];
        r.queued     = pred_queued[slot];
        r.max_queued = pred_max_q[slot];
        r.status     = pred_status[slot];
      end
    endcase
    return r;
  endfunction

  // Offer one request after a random gap; hold it until accepted, then record the
  // expected result. Returns right after the accepting edge with tvalid still high.
  task automatic send_request(action_e act, logic [2:0] slot, logic typed,
                              sched_result_t typed_res);
    int            gap;
    sched_result_t pred;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {3'b000, slot, act};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_schedule(act, slot);
    pending_results.push_back(typed ? typed_res : pred);
    if (act == ACT_DISPATCH && pred.dispatch_valid) last_dispatched = pred.dispatch_slot;
  endtask

  // Drop the request valid and wait until every expected result has drained.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // One period register write; the block must be idle.
  task automatic write_period(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pred_period[idx] = val;
  endtask

  // Rewrite all eight periods from the given mix.
  task automatic program_periods(period_mix_e mix);
    logic [15:0] val;
    int          r;
    wait_idle();
    for (int i = 0; i < SLOTS; i++) begin
      r = $urandom_range(0, 3);
      case (mix)
        PER_ONES:  val = 16'd1;
        PER_TINY:  val = 16'($urandom_range(1, 3));
        PER_SHORT: val = 16'($urandom_range(1, 12));
        PER_MAX:   val = 16'hFFFF;
        default: begin
          if (r < 2)       val = 16'($urandom_range(1, 8));
          else if (r == 2) val = 16'($urandom_range(9, 64));
          else             val = 16'($urandom_range(1, 65535));
        end
      endcase
      write_period(3'(i), val);
    end
  endtask

  task automatic check_field(string name, int unsigned expd, int unsigned act);
    if (expd != act) begin
      $error("%s: expected %0d, actual %0d", name, expd, act);
      fail_count++;
    end
  endtask

  // Result receiver: random stalls on tready, set at the falling edge.
  int stall_left = 0;
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, tdata %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        got_res  = sched_result_t'(m_axis_tdata_o[$bits(sched_result_t)-1:0]);
        check_field("dispatch_valid", want_res.dispatch_valid, got_res.dispatch_valid);
        check_field("dispatch_slot", want_res.dispatch_slot, got_res.dispatch_slot);
        check_field("released_mask", want_res.released_mask, got_res.released_mask);
        check_field("missed_mask", want_res.missed_mask, got_res.missed_mask);
        check_field("slot_missed", want_res.missed, got_res.missed);
        check_field("slot_queued", want_res.queued, got_res.queued);
        check_field("slot_max_queued", want_res.max_queued, got_res.max_queued);
        check_field("slot_status", want_res.status, got_res.status);
      end
    end
  end

  // Main sequence: reset, directed plan, random phases, drain.
  initial begin
    action_e    act;
    logic [2:0] slot_sel;
    int         pick;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;

    // Reset state: default periods, time and counters cleared, every slot blocked.
    pred_time = 32'd0;
    for (int i = 0; i < SLOTS; i++) begin
      pred_period[i]   = DEFAULT_PERIOD[i];
      pred_next_rel[i] = 32'd0;
      pred_status[i]   = ST_BLOCKED;
      pred_missed[i]   = 16'd0;
      pred_queued[i]   = 16'd0;
      pred_max_q[i]    = 16'd0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // kind, action, slot/index, value, typed, expected
    directed_plan.push_back('{ROW_REQ, ACT_READ,     3'd0, 16'd0, 1'b1, BLOCKED_VIEW});
    directed_plan.push_back('{ROW_REQ, ACT_READ,     3'd7, 16'd0, 1'b1, BLOCKED_VIEW});
    // Nothing is ready yet: dispatch finds no slot.
    directed_plan.push_back('{ROW_REQ, ACT_DISPATCH, 3'd0, 16'd0, 1'b1, NOTHING_READY});
    // Complete on a slot that is already blocked.
    directed_plan.push_back('{ROW_REQ, ACT_COMPLETE, 3'd3, 16'd0, 1'b1, BLOCKED_VIEW});
    // Shortest periods on the two top slots so deadlines are missed early.
    directed_plan.push_back('{ROW_CFG, ACT_TICK,     3'd0, 16'd1, 1'b0, '0});
    directed_plan.push_back('{ROW_CFG, ACT_TICK,     3'd1, 16'd2, 1'b0, '0});
    // First tick releases every slot: all next release times start at zero.
    directed_plan.push_back('{ROW_REQ, ACT_TICK,     3'd0, 16'd0, 1'b1, FIRST_RELEASE});
    directed_plan.push_back('{ROW_REQ, ACT_DISPATCH, 3'd0, 16'd0, 1'b1, SLOT0_DISPATCHED});
    // Slot 0 misses while executing, slot 1 while ready.
    directed_plan.push_back('{ROW_REQ, ACT_TICK,     3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_DISPATCH, 3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_READ,     3'd0, 16'd0, 1'b0, '0});
    // Complete an executing slot.
    directed_plan.push_back('{ROW_REQ, ACT_COMPLETE, 3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_TICK,     3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_DISPATCH, 3'd0, 16'd0, 1'b0, '0});
    // Complete a ready slot.
    directed_plan.push_back('{ROW_REQ, ACT_COMPLETE, 3'd7, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_READ,     3'd7, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_TICK,     3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_TICK,     3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_DISPATCH, 3'd0, 16'd0, 1'b0, '0});
    directed_plan.push_back('{ROW_REQ, ACT_READ,     3'd1, 16'd0, 1'b0, '0});

    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_CFG) begin
        wait_idle();
        write_period(directed_plan[k].slot, directed_plan[k].value);
      end else begin
        send_request(directed_plan[k].action, directed_plan[k].slot,
                     directed_plan[k].typed, directed_plan[k].expd);
      end
    end

    // Random phases: ticks, dispatches and completes of the running job dominate,
    // with reads and stray completes mixed in.
    for (int p = 0; p < 8; p++) begin
      program_periods(PHASE_MIX[p]);
      for (int n = 0; n < PHASE_LEN[p]; n++) begin
        // Alternate stretches with and without idling.
        if (n % 64 == 0) no_idle = PHASE_CALM[p] || ($urandom_range(0, 3) == 0);
        pick     = $urandom_range(0, 99);
        slot_sel = 3'($urandom_range(0, 7));
        if (pick < 35) begin
          act = ACT_TICK;
        end else if (pick < 65) begin
          act = ACT_DISPATCH;
        end else if (pick < 85) begin
          act = ACT_COMPLETE;
          if ($urandom_range(0, 9) < 7) slot_sel = last_dispatched;
        end else begin
          act = ACT_READ;
        end
        send_request(act, slot_sel, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
